### src/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// shared types and codes for the source line counter
// ----------------------------------------------------------------------------
package slc_pkg;

    // pending opener codes
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_SLASH = 2'd1;
    localparam logic [1:0] PEND_LINE  = 2'd2;
    localparam logic [1:0] PEND_BLOCK = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_QUOTE   = 8'd34;
    localparam logic [7:0] CHAR_STAR    = 8'd42;
    localparam logic [7:0] CHAR_SLASH   = 8'd47;

    // per-line scanner state
    typedef struct packed {
        logic       block;     // inside block comment
        logic       line_cmt;  // inside line comment
        logic       has_code;  // line holds code so far
        logic [1:0] pend;      // pending opener kind
        logic       quote;     // quote sat before the opener
        logic [7:0] prev;      // previous code character
        logic       star;      // star seen that may close
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        block:    1'b0,
        line_cmt: 1'b0,
        has_code: 1'b0,
        pend:     PEND_NONE,
        quote:    1'b0,
        prev:     8'd0,
        star:     1'b0
    };

endpackage

### src/slc_scan.sv
// ----------------------------------------------------------------------------
// slc_scan
// next-state logic of the comment scanner for one character
// ----------------------------------------------------------------------------
module slc_scan (
    input  slc_pkg::t_scan_state i_state,
    input  logic [7:0]           i_char,
    input  logic                 i_final,
    output slc_pkg::t_scan_state o_state,
    output logic                 o_emit,
    output logic                 o_counted
);

    function automatic slc_pkg::t_scan_state plain_char(slc_pkg::t_scan_state s,
                                                        logic [7:0] c);
        slc_pkg::t_scan_state r;
        r = s;
        if (c == slc_pkg::CHAR_SLASH) begin
            r.pend  = slc_pkg::PEND_SLASH;
            r.quote = (s.prev == slc_pkg::CHAR_QUOTE);
        end else begin
            if (c != slc_pkg::CHAR_SPACE) begin
                r.has_code = 1'b1;
            end
            r.prev = c;
        end
        return r;
    endfunction

    function automatic slc_pkg::t_scan_state comment_char(slc_pkg::t_scan_state s,
                                                          logic [7:0] c);
        slc_pkg::t_scan_state r;
        r = s;
        if (s.star && c == slc_pkg::CHAR_SLASH) begin
            r.block = 1'b0;
            r.star  = 1'b0;
        end else begin
            r.star = (c == slc_pkg::CHAR_STAR);
        end
        return r;
    endfunction

    slc_pkg::t_scan_state w_scan;
    slc_pkg::t_scan_state w_fin;
    logic                 w_is_nl;

    assign w_is_nl = (i_char == slc_pkg::CHAR_NEWLINE);

    // character scan
    always_comb begin
        w_scan = i_state;
        if (!w_is_nl && !i_state.line_cmt) begin
            if (i_state.block) begin
                w_scan = comment_char(i_state, i_char);
            end else begin
                w_scan.pend = slc_pkg::PEND_NONE;
                case (i_state.pend)
                    slc_pkg::PEND_SLASH: begin
                        if (i_char == slc_pkg::CHAR_SLASH || i_char == slc_pkg::CHAR_STAR) begin
                            if (i_state.quote) begin
                                w_scan.pend = (i_char == slc_pkg::CHAR_SLASH) ?
                                              slc_pkg::PEND_LINE : slc_pkg::PEND_BLOCK;
                            end else if (i_char == slc_pkg::CHAR_SLASH) begin
                                w_scan.line_cmt = 1'b1;
                            end else begin
                                w_scan.block = 1'b1;
                                w_scan.star  = 1'b0;
                            end
                        end else begin
                            // lone slash is code
                            w_scan.has_code = 1'b1;
                            w_scan.prev     = slc_pkg::CHAR_SLASH;
                            w_scan          = plain_char(w_scan, i_char);
                        end
                    end
                    slc_pkg::PEND_LINE, slc_pkg::PEND_BLOCK: begin
                        if (i_char == slc_pkg::CHAR_QUOTE) begin
                            // quoted opener, its characters are code
                            w_scan.has_code = 1'b1;
                            w_scan          = plain_char(w_scan, i_char);
                        end else if (i_state.pend == slc_pkg::PEND_LINE) begin
                            w_scan.line_cmt = 1'b1;
                        end else begin
                            w_scan.block = 1'b1;
                            w_scan.star  = 1'b0;
                            w_scan       = comment_char(w_scan, i_char);
                        end
                    end
                    default: begin
                        w_scan = plain_char(w_scan, i_char);
                    end
                endcase
            end
        end
    end

    // end of line handling
    always_comb begin
        w_fin = w_scan;
        if (w_scan.pend == slc_pkg::PEND_SLASH) begin
            w_fin.has_code = 1'b1;
        end else if (w_scan.pend == slc_pkg::PEND_BLOCK) begin
            w_fin.block = 1'b1;
            w_fin.star  = 1'b0;
        end
    end

    assign o_emit    = w_is_nl || i_final;
    assign o_counted = w_fin.has_code;

    always_comb begin
        o_state = w_scan;
        if (o_emit) begin
            o_state          = w_fin;
            o_state.has_code = 1'b0;
            o_state.line_cmt = 1'b0;
            o_state.pend     = slc_pkg::PEND_NONE;
            o_state.quote    = 1'b0;
            o_state.prev     = 8'd0;
            o_state.star     = 1'b0;
            if (i_final) begin
                o_state = slc_pkg::SCAN_RESET;
            end
        end
    end

endmodule

### src/source_code_line_counter.sv
// ----------------------------------------------------------------------------
// source_code_line_counter
// counts lines of c source that hold code outside comments
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_text_byte, i_final_byte
//  out     | output    | o_out_valid/i_out_stall | o_line_counted, o_total_lines, o_end_of_text
//
//  one byte per cycle while the input does not stall: each accepted byte is held in
//  the input register, then one pass of the scanner logic updates the state and, on a
//  newline or the final byte, loads the result register, which drives the result
//  outputs.
//  reset is synchronous and clears scanner state, total and both valid flags.
//  while a result is stalled, bytes that end no line keep flowing; the input
//  stalls only when a byte that ends a line waits in the input register.
//
module source_code_line_counter #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_line_counted,
    output logic [31:0] o_total_lines,
    output logic        o_end_of_text
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    // scanner state and running total
    slc_pkg::t_scan_state   r_state;
    slc_pkg::t_scan_state   n_state;
    logic [COUNT_WIDTH-1:0] r_total;
    logic [COUNT_WIDTH-1:0] n_total;

    // result register
    logic r_out_valid;
    logic r_out_counted;
    logic r_out_last;
    logic [31:0] r_out_total;

    logic w_emit;
    logic w_counted;
    logic w_advance;
    logic [63:0] w_total_ext;

    slc_scan u_scan (
        .i_state   (r_state),
        .i_char    (r_in_byte),
        .i_final   (r_in_final),
        .o_state   (n_state),
        .o_emit    (w_emit),
        .o_counted (w_counted)
    );

    // a byte with no result always moves; one with a result needs the slot
    assign w_advance  = r_in_valid && (!w_emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    // saturating count of code lines
    always_comb begin
        n_total = r_total;
        if (w_counted && (r_total != {COUNT_WIDTH{1'b1}})) begin
            n_total = r_total + COUNT_WIDTH'(1);
        end
    end

    assign w_total_ext = 64'(n_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte  <= i_text_byte;
            r_in_final <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slc_pkg::SCAN_RESET;
            r_total <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
            if (w_emit) begin
                // the final byte starts the next text afresh
                r_total <= r_in_final ? '0 : n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_counted <= w_counted;
            r_out_last    <= r_in_final;
            r_out_total   <= w_total_ext[31:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_counted = r_out_counted;
    assign o_total_lines  = r_out_total;
    assign o_end_of_text  = r_out_last;

`ifndef ASSERT_OFF
    // reset leaves no transaction in flight and a zero total
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid && r_total == '0))
        else $error("state not cleared by reset");

    // inside a block comment no line comment and no pending opener is active
    a_block_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.block |-> (!r_state.line_cmt && r_state.pend == slc_pkg::PEND_NONE))
        else $error("block comment overlaps other scanner state");

    // a result may only be replaced once the old one is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_total)))
        else $error("pending result lost");
`endif

endmodule

### sim/slc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slc_checker
// watches both channels of the line counter, predicts each line result from
// the accepted bytes and compares every accepted result field by field
// ----------------------------------------------------------------------------
module slc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_line_counted,
    input  logic [31:0] i_total_lines,
    input  logic        i_end_of_text,
    output int          o_mismatches,
    output int          o_waiting,
    output int          o_checked
);

    typedef struct {
        logic        counted;
        logic [31:0] total;
        logic        last;
    } t_line_result;

    t_line_result expected_lines[$];

    // predicted scanner state
    logic        in_block;
    logic        in_line_cmt;
    logic        has_code;
    logic [1:0]  pend;
    logic        quote_pre;
    logic [7:0]  prev_ch;
    logic        star_close;
    logic [31:0] code_total;

    int mismatch_cnt = 0;
    int checked_cnt  = 0;

    task automatic clear_line();
        in_line_cmt = 1'b0;
        has_code    = 1'b0;
        pend        = slc_pkg::PEND_NONE;
        quote_pre   = 1'b0;
        prev_ch     = 8'd0;
        star_close  = 1'b0;
    endtask

    task automatic clear_text();
        clear_line();
        in_block   = 1'b0;
        code_total = '0;
    endtask

    task automatic enter_block();
        in_block   = 1'b1;
        star_close = 1'b0;
    endtask

    // character outside any comment
    task automatic take_plain(input logic [7:0] c);
        if (c == slc_pkg::CHAR_SLASH) begin
            pend      = slc_pkg::PEND_SLASH;
            quote_pre = (prev_ch == slc_pkg::CHAR_QUOTE);
            return;
        end
        if (c != slc_pkg::CHAR_SPACE)
            has_code = 1'b1;
        prev_ch = c;
    endtask

    // character inside a block comment
    task automatic take_comment(input logic [7:0] c);
        if (star_close && c == slc_pkg::CHAR_SLASH) begin
            in_block   = 1'b0;
            star_close = 1'b0;
        end else begin
            star_close = (c == slc_pkg::CHAR_STAR);
        end
    endtask

    task automatic scan_byte(input logic [7:0] c);
        logic [1:0] kind;
        kind = pend;
        if (in_line_cmt)
            return;
        if (in_block) begin
            take_comment(c);
            return;
        end
        pend = slc_pkg::PEND_NONE;
        if (kind == slc_pkg::PEND_SLASH) begin
            if (c == slc_pkg::CHAR_SLASH || c == slc_pkg::CHAR_STAR) begin
                // quoted opener waits for the quote after it
                if (quote_pre)
                    pend = (c == slc_pkg::CHAR_SLASH) ? slc_pkg::PEND_LINE
                                                      : slc_pkg::PEND_BLOCK;
                else if (c == slc_pkg::CHAR_SLASH)
                    in_line_cmt = 1'b1;
                else
                    enter_block();
                return;
            end
            has_code = 1'b1;
            prev_ch  = slc_pkg::CHAR_SLASH;
            take_plain(c);
        end else if (kind == slc_pkg::PEND_LINE || kind == slc_pkg::PEND_BLOCK) begin
            if (c == slc_pkg::CHAR_QUOTE) begin
                has_code = 1'b1;
                take_plain(c);
            end else if (kind == slc_pkg::PEND_LINE) begin
                in_line_cmt = 1'b1;
            end else begin
                enter_block();
                take_comment(c);
            end
        end else begin
            take_plain(c);
        end
    endtask

    task automatic close_line(input logic last);
        t_line_result r;
        if (pend == slc_pkg::PEND_SLASH)
            has_code = 1'b1;
        else if (pend == slc_pkg::PEND_BLOCK)
            enter_block();
        if (has_code && code_total != '1)
            code_total = code_total + 32'd1;
        r.counted = has_code;
        r.total   = code_total;
        r.last    = last;
        expected_lines.push_back(r);
        clear_line();
        if (last)
            clear_text();
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch on result %0d, %s: expected %0d, got %0d",
                 checked_cnt, field, want, got);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_line_result want;
        if (!i_rst_n) begin
            clear_text();
            expected_lines.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_lines.size() == 0) begin
                    report_mismatch("transaction with nothing expected", 32'd0, 32'd1);
                end else begin
                    want = expected_lines.pop_front();
                    if (i_line_counted !== want.counted)
                        report_mismatch("line_counted", 32'(want.counted),
                                        32'(i_line_counted));
                    if (i_total_lines !== want.total)
                        report_mismatch("total_lines", want.total, i_total_lines);
                    if (i_end_of_text !== want.last)
                        report_mismatch("end_of_text", 32'(want.last),
                                        32'(i_end_of_text));
                end
                checked_cnt++;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_text_byte != slc_pkg::CHAR_NEWLINE)
                    scan_byte(i_text_byte);
                if (i_text_byte == slc_pkg::CHAR_NEWLINE || i_final_byte)
                    close_line(i_final_byte);
            end
        end
        o_mismatches <= mismatch_cnt;
        o_waiting    <= expected_lines.size();
        o_checked    <= checked_cnt;
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// line counter test: directed comment and quote cases, then random c-like
// text with idle cycles on both sides, a long output hold and a drain pause
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_BYTES = 950;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_text_byte  = 8'd0;
    logic        i_final_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall  = 1'b0;
    logic        o_line_counted;
    logic [31:0] o_total_lines;
    logic        o_end_of_text;

    int mismatches;
    int waiting;
    int checked;

    // stimulus side controls for the receiver process
    int   hold_req   = 0;
    logic rx_quiet   = 1'b0;
    // receiver-owned hold bookkeeping
    int   hold_taken = 0;
    int   hold_left  = 0;

    logic tx_quiet   = 1'b0;
    int   bytes_sent = 0;
    int   texts_sent = 0;
    int   cycle_cnt  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    source_code_line_counter #(
        .COUNT_WIDTH (32)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_final_byte   (i_final_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_line_counted (o_line_counted),
        .o_total_lines  (o_total_lines),
        .o_end_of_text  (o_end_of_text)
    );

    slc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_final_byte   (i_final_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_line_counted (o_line_counted),
        .i_total_lines  (o_total_lines),
        .i_end_of_text  (o_end_of_text),
        .o_mismatches   (mismatches),
        .o_waiting      (waiting),
        .o_checked      (checked)
    );

    // watchdog, far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_cnt, waiting);
            $display("tb: failure");
            $finish;
        end
    end

    // result receiver: random stall, quiet stretch, or a long counted hold
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req != hold_taken) begin
            hold_taken  <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (rx_quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 9);
        end
    end

    // offer one byte, with random idle cycles first, and hold it until taken
    task automatic send_byte(input logic [7:0] c, input logic last);
        if (!tx_quiet) begin
            while ($urandom_range(99) < 9) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_text_byte  <= c;
        i_final_byte <= last;
        do
            @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall));
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic ends_text);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], ends_text && (i == s.len() - 1));
    endtask

    // sender stops until every predicted line result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (waiting != 0);
    endtask

    // c-like alphabet, heavy on the comment and quote characters
    function automatic logic [7:0] pick_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 18)      return slc_pkg::CHAR_SPACE;
        else if (roll < 34) return slc_pkg::CHAR_SLASH;
        else if (roll < 48) return slc_pkg::CHAR_STAR;
        else if (roll < 58) return slc_pkg::CHAR_QUOTE;
        else if (roll < 67) return slc_pkg::CHAR_NEWLINE;
        else if (roll < 92) return 8'd97 + 8'($urandom_range(25));
        else                return 8'($urandom_range(255));
    endfunction

    task automatic send_random_text(input int len);
        for (int i = 0; i < len; i++)
            send_byte(pick_char(), i == len - 1);
        texts_sent++;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: blank and tab lines, opener sharing its star with the
        // closer, closer on the next line, quoted openers, quote test across
        // a closed comment, lone slash at line end, extreme bytes
        send_text(" \n\t\n/*/\n*///\n\"//\"\n\"/**//*\"\n/\n", 1'b0);
        send_byte(8'hFF, 1'b1);
        texts_sent++;
        send_byte(8'h00, 1'b0);
        send_byte(slc_pkg::CHAR_NEWLINE, 1'b1);
        texts_sent++;
        wait_drained();

        while (bytes_sent < RANDOM_BYTES) begin
            // long output hold while bytes keep coming, fills the pipe
            if (texts_sent == 6)
                hold_req <= hold_req + 1;
            if (texts_sent == 12)
                wait_drained();
            // stretch with no idling on either side
            if (texts_sent == 16) begin
                tx_quiet <= 1'b1;
                rx_quiet <= 1'b1;
            end
            if (texts_sent == 22) begin
                tx_quiet <= 1'b0;
                rx_quiet <= 1'b0;
            end
            if ($urandom_range(9) == 0)
                send_random_text($urandom_range(150, 80));
            else
                send_random_text($urandom_range(40, 1));
        end

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("covered %0d bytes in %0d texts, %0d line results compared",
                 bytes_sent, texts_sent, checked);
        $display("included comment and quote corner cases, a long output hold",
                 " and a drain pause");
        if (mismatches == 0 && waiting == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
